/* rtl/core/wstk_pkg.sv */
// Shared widths, codes and word types for the weighted-score top-k keeper.
package wstk_pkg;

  // Defaults and sizes
  localparam int MAX_KEEP_DEF = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SCORE_W    = 40;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 32;
  localparam int REV_W      = 4;
  localparam int RIDX_W     = 6;
  localparam int CNT_W      = 7;
  localparam int WEIGHT_W   = 16;
  localparam int MODE_W     = 2;
  localparam int PROD_W     = WEIGHT_W + SPEED_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Opcodes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Score modes
  localparam logic [MODE_W-1:0] MODE_DEPART   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOTAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARRIVE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT     = 2'd2;

  // Reset values
  localparam logic [MODE_W-1:0]   SCORE_MODE_RST     = MODE_WEIGHTED;
  localparam logic [WEIGHT_W-1:0] ARRIVAL_WEIGHT_RST = 16'd256;
  localparam logic [CNT_W-1:0]    KEEP_COUNT_RST     = 7'd8;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Scored word passed from front to back
  typedef struct packed {
    logic               opcode;
    logic               feasible;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  depart_time;
    logic [TIME_W-1:0]  flight_time;
    logic [SPEED_W-1:0] depart_dv;
    logic [SPEED_W-1:0] arrive_speed;
    logic [REV_W-1:0]   revs;
    logic [RIDX_W-1:0]  read_index;
  } item_t;

  // One kept list entry
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  depart_time;
    logic [TIME_W-1:0]  flight_time;
    logic [SPEED_W-1:0] depart_dv;
    logic [SPEED_W-1:0] arrive_speed;
    logic [REV_W-1:0]   revs;
  } entry_t;

endpackage

/* rtl/core/wstk_front.sv */
// Front end: accepts input words, multiplies the arrival weight and forms the score.
module wstk_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic                          in_feasible,
  input  logic [31:0]                   in_depart_time,
  input  logic [31:0]                   in_flight_time,
  input  logic [31:0]                   in_depart_dv,
  input  logic [31:0]                   in_arrive_speed,
  input  logic [3:0]                    in_revolution_count,
  input  logic [5:0]                    in_read_index,
  input  logic [wstk_pkg::MODE_W-1:0]   score_mode,
  input  logic [wstk_pkg::WEIGHT_W-1:0] arrival_weight,
  output logic                          push,
  input  logic                          push_ready,
  output wstk_pkg::item_t               push_item
);
  import wstk_pkg::*;

  logic               v_r, v_nxt;
  logic               op_r, feas_r;
  logic [TIME_W-1:0]  dep_r, fl_r;
  logic [SPEED_W-1:0] dv_r, spd_r;
  logic [REV_W-1:0]   revs_r;
  logic [RIDX_W-1:0]  ridx_r;
  logic [PROD_W-1:0]  prod_r;
  logic               in_acc;
  logic [SCORE_W:0]   wsum;
  logic [SCORE_W-1:0] score;

  // Hold the word while the queue is full
  assign in_stall = v_r && !push_ready;
  assign in_acc   = in_valid && !in_stall;
  assign push     = v_r && push_ready;

  always_comb begin
    v_nxt = v_r;
    if (in_acc) begin
      v_nxt = 1'b1;
    end else if (push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Capture the word and the weighted arrival product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_opcode;
      feas_r <= in_feasible;
      dep_r  <= in_depart_time;
      fl_r   <= in_flight_time;
      dv_r   <= in_depart_dv;
      spd_r  <= in_arrive_speed;
      revs_r <= in_revolution_count;
      ridx_r <= in_read_index;
      prod_r <= PROD_W'(arrival_weight) * PROD_W'(in_arrive_speed);
    end
  end

  // Score by mode; drop eight fraction bits of the product and saturate
  assign wsum = (SCORE_W+1)'(dv_r) + (SCORE_W+1)'(prod_r[PROD_W-1:8]);

  always_comb begin
    case (score_mode)
      MODE_DEPART: score = SCORE_W'(dv_r);
      MODE_TOTAL:  score = SCORE_W'(dv_r) + SCORE_W'(spd_r);
      MODE_ARRIVE: score = SCORE_W'(spd_r);
      default:     score = wsum[SCORE_W] ? SCORE_MAX : wsum[SCORE_W-1:0];
    endcase
  end

  always_comb begin
    push_item.opcode       = op_r;
    push_item.feasible     = feas_r;
    push_item.score        = score;
    push_item.depart_time  = dep_r;
    push_item.flight_time  = fl_r;
    push_item.depart_dv    = dv_r;
    push_item.arrive_speed = spd_r;
    push_item.revs         = revs_r;
    push_item.read_index   = ridx_r;
  end

endmodule

/* rtl/core/wstk_queue.sv */
// Short queue of scored words between the front and the back.
module wstk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            push_ready,
  input  wstk_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output wstk_pkg::item_t pop_item
);
  import wstk_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;

  assign push_ready = cnt_r != QC_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/wstk_back.sv */
// Back end: sorted insertion chain, entry read-out and the result register.
module wstk_back #(
  parameter int MAX_KEEP = wstk_pkg::MAX_KEEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop,
  input  wstk_pkg::item_t             pop_item,
  input  logic [wstk_pkg::CNT_W-1:0]  keep_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_entry_valid,
  output logic [39:0]                 out_entry_score,
  output logic [31:0]                 out_entry_depart_time,
  output logic [31:0]                 out_entry_flight_time,
  output logic [31:0]                 out_entry_depart_dv,
  output logic [31:0]                 out_entry_arrive_speed,
  output logic [3:0]                  out_entry_revolutions,
  output logic [6:0]                  out_list_count,
  output logic [6:0]                  out_insert_rank
);
  import wstk_pkg::*;

  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  entry_t              list_r   [MAX_KEEP];
  entry_t              list_nxt [MAX_KEEP];
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic                out_v_r, out_v_nxt;
  logic [MAX_KEEP-1:0] at_or_after;
  logic [MAX_KEEP-1:0] first;
  logic [CNT_W-1:0]    rank_enc, rank, limit, last, grown;
  logic                do_offer, do_ins, rd_hit;
  entry_t              new_entry, rd_entry;

  // Pop when the result register is free or being taken
  assign pop = pop_valid && (!out_v_r || !out_stall);

  assign limit = (keep_count < CNT_W'(MAX_KEEP)) ? keep_count : CNT_W'(MAX_KEEP);

  always_comb begin
    new_entry.score        = pop_item.score;
    new_entry.depart_time  = pop_item.depart_time;
    new_entry.flight_time  = pop_item.flight_time;
    new_entry.depart_dv    = pop_item.depart_dv;
    new_entry.arrive_speed = pop_item.arrive_speed;
    new_entry.revs         = pop_item.revs;
  end

  // Compare every lane against the key; used lanes that order strictly before it stay put
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      at_or_after[i] = !((CNT_W'(i) < total_r) &&
        ({list_r[i].score, list_r[i].depart_time, list_r[i].flight_time} <
         {pop_item.score, pop_item.depart_time, pop_item.flight_time}));
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      first[i] = at_or_after[i] && ((i == 0) || !at_or_after[(i == 0) ? 0 : i - 1]);
    end
    rank_enc = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (first[i]) begin
        rank_enc = rank_enc | CNT_W'(i);
      end
    end
  end

  assign rank     = (|first) ? rank_enc : CNT_W'(MAX_KEEP);
  assign do_offer = pop && (pop_item.opcode == OP_OFFER) && pop_item.feasible && (limit != '0);
  assign do_ins   = do_offer && (rank < limit);
  assign last     = (total_r < limit) ? total_r : limit - 1'b1;
  assign grown    = total_r + 1'b1;

  // Shift lanes below the insertion point down by one, up to the limit
  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      list_nxt[j] = list_r[j];
      if (do_ins) begin
        if (first[j]) begin
          list_nxt[j] = new_entry;
        end else if ((j > 0) && at_or_after[(j == 0) ? 0 : j - 1] &&
                     (CNT_W'(j) <= last)) begin
          list_nxt[j] = list_r[(j == 0) ? 0 : j - 1];
        end
      end
    end
  end

  // Count after a feasible offer, clipped to the limit
  always_comb begin
    total_nxt = total_r;
    if (do_offer) begin
      total_nxt = (grown > limit) ? limit : grown;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      list_r[j] <= list_nxt[j];
    end
  end

  // Read one kept entry by rank
  assign rd_hit   = (CNT_W'(pop_item.read_index) < total_r);
  assign rd_entry = list_r[pop_item.read_index[IDX_W-1:0]];

  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (pop) begin
      if ((pop_item.opcode == OP_READ) && rd_hit) begin
        out_entry_valid        <= 1'b1;
        out_entry_score        <= rd_entry.score;
        out_entry_depart_time  <= rd_entry.depart_time;
        out_entry_flight_time  <= rd_entry.flight_time;
        out_entry_depart_dv    <= rd_entry.depart_dv;
        out_entry_arrive_speed <= rd_entry.arrive_speed;
        out_entry_revolutions  <= rd_entry.revs;
      end else begin
        out_entry_valid        <= 1'b0;
        out_entry_score        <= '0;
        out_entry_depart_time  <= '0;
        out_entry_flight_time  <= '0;
        out_entry_depart_dv    <= '0;
        out_entry_arrive_speed <= '0;
        out_entry_revolutions  <= '0;
      end
      out_list_count  <= total_nxt;
      out_insert_rank <= do_ins ? rank : keep_count;
    end
  end

  assign out_valid = out_v_r;

endmodule

/* rtl/core/weighted_score_top_k_keeper_top.sv */
// Weighted-score top-k keeper: front scoring stage, word queue and sorted insertion back end.
// Path: an accepted word is registered in the front stage, stored in the queue, then loaded into the result register.
// Throughput: one word per cycle while nothing stalls; the whole kept list is compared and shifted combinationally.
// A full two-word queue stalls the front; a stalled result register stalls the back.
// Reset (synchronous, rst_n low) empties the list and queue and restores the register defaults.
module weighted_score_top_k_keeper_top #(
  parameter int MAX_KEEP = wstk_pkg::MAX_KEEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wstk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wstk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic                            in_feasible,
  input  logic [31:0]                     in_depart_time,
  input  logic [31:0]                     in_flight_time,
  input  logic [31:0]                     in_depart_dv,
  input  logic [31:0]                     in_arrive_speed,
  input  logic [3:0]                      in_revolution_count,
  input  logic [5:0]                      in_read_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_entry_valid,
  output logic [39:0]                     out_entry_score,
  output logic [31:0]                     out_entry_depart_time,
  output logic [31:0]                     out_entry_flight_time,
  output logic [31:0]                     out_entry_depart_dv,
  output logic [31:0]                     out_entry_arrive_speed,
  output logic [3:0]                      out_entry_revolutions,
  output logic [6:0]                      out_list_count,
  output logic [6:0]                      out_insert_rank
);
  import wstk_pkg::*;

  logic [MODE_W-1:0]   score_mode_r;
  logic [WEIGHT_W-1:0] arrival_weight_r;
  logic [CNT_W-1:0]    keep_count_r;
  logic                push, push_ready, pop, pop_valid;
  item_t               push_item, pop_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_mode_r     <= SCORE_MODE_RST;
      arrival_weight_r <= ARRIVAL_WEIGHT_RST;
      keep_count_r     <= KEEP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCORE_MODE:     score_mode_r     <= cfg_data[MODE_W-1:0];
        CFG_ARRIVAL_WEIGHT: arrival_weight_r <= cfg_data[WEIGHT_W-1:0];
        CFG_KEEP_COUNT:     keep_count_r     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  wstk_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_feasible         (in_feasible),
    .in_depart_time      (in_depart_time),
    .in_flight_time      (in_flight_time),
    .in_depart_dv        (in_depart_dv),
    .in_arrive_speed     (in_arrive_speed),
    .in_revolution_count (in_revolution_count),
    .in_read_index       (in_read_index),
    .score_mode          (score_mode_r),
    .arrival_weight      (arrival_weight_r),
    .push                (push),
    .push_ready          (push_ready),
    .push_item           (push_item)
  );

  wstk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  wstk_back #(
    .MAX_KEEP (MAX_KEEP)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .pop_valid              (pop_valid),
    .pop                    (pop),
    .pop_item               (pop_item),
    .keep_count             (keep_count_r),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_entry_valid        (out_entry_valid),
    .out_entry_score        (out_entry_score),
    .out_entry_depart_time  (out_entry_depart_time),
    .out_entry_flight_time  (out_entry_flight_time),
    .out_entry_depart_dv    (out_entry_depart_dv),
    .out_entry_arrive_speed (out_entry_arrive_speed),
    .out_entry_revolutions  (out_entry_revolutions),
    .out_list_count         (out_list_count),
    .out_insert_rank        (out_insert_rank)
  );

endmodule

/* rtl/core/wstk_checker.sv */
// Port-level checks for the top-k keeper, bound to the top level.
module wstk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_entry_valid,
  input logic [39:0] out_entry_score,
  input logic [31:0] out_entry_depart_time,
  input logic [31:0] out_entry_flight_time,
  input logic [31:0] out_entry_depart_dv,
  input logic [31:0] out_entry_arrive_speed,
  input logic [3:0]  out_entry_revolutions,
  input logic [6:0]  out_list_count,
  input logic [6:0]  out_insert_rank
);

  // A stalled result word holds its score, list count and insert rank
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_score) &&
      $stable(out_list_count) && $stable(out_insert_rank))
    else $error("stalled result word changed");

  // Reset drops the result word
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A valid read implies a non-empty list
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_list_count != 7'd0)
    else $error("entry read from an empty list");

  // A miss carries zero entry fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_entry_score == 40'd0 &&
      out_entry_depart_time == 32'd0 && out_entry_flight_time == 32'd0 &&
      out_entry_depart_dv == 32'd0 && out_entry_arrive_speed == 32'd0 &&
      out_entry_revolutions == 4'd0)
    else $error("entry fields not zero on a miss");

  // The list never grows past its largest size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_list_count <= 7'd64)
    else $error("list count out of range");

endmodule

bind weighted_score_top_k_keeper_top wstk_checker u_wstk_checker (.*);

/* dv/wstk_ranking_checker.sv */
// Ranking checker: tracks the kept list, predicts each result word and compares it.
module wstk_ranking_checker #(
  parameter int MAX_KEEP = wstk_pkg::MAX_KEEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wstk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wstk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_opcode,
  input  logic                            in_feasible,
  input  logic [31:0]                     in_depart_time,
  input  logic [31:0]                     in_flight_time,
  input  logic [31:0]                     in_depart_dv,
  input  logic [31:0]                     in_arrive_speed,
  input  logic [3:0]                      in_revolution_count,
  input  logic [5:0]                      in_read_index,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_entry_valid,
  input  logic [39:0]                     out_entry_score,
  input  logic [31:0]                     out_entry_depart_time,
  input  logic [31:0]                     out_entry_flight_time,
  input  logic [31:0]                     out_entry_depart_dv,
  input  logic [31:0]                     out_entry_arrive_speed,
  input  logic [3:0]                      out_entry_revolutions,
  input  logic [6:0]                      out_list_count,
  input  logic [6:0]                      out_insert_rank,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wstk_pkg::*;

  // One result word as the block returns it
  typedef struct packed {
    logic               entry_valid;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  depart_time;
    logic [TIME_W-1:0]  flight_time;
    logic [SPEED_W-1:0] depart_dv;
    logic [SPEED_W-1:0] arrive_speed;
    logic [REV_W-1:0]   revs;
    logic [CNT_W-1:0]   list_count;
    logic [CNT_W-1:0]   insert_rank;
  } result_word_t;

  logic [MODE_W-1:0]   mode_reg;
  logic [WEIGHT_W-1:0] weight_reg;
  logic [CNT_W-1:0]    keep_reg;
  entry_t              rank_list [MAX_KEEP];
  int                  list_len;
  result_word_t        awaited_results [$];

  // Score of a candidate under the current mode; the weighted sum is saturated to 40 bits
  function automatic logic [SCORE_W-1:0] candidate_score(input logic [31:0] dv,
                                                         input logic [31:0] spd);
    logic [PROD_W-1:0]  prod;
    logic [SCORE_W:0]   sum;
    prod = weight_reg * spd;
    case (mode_reg)
      MODE_DEPART: return SCORE_W'(dv);
      MODE_TOTAL:  return SCORE_W'(dv) + SCORE_W'(spd);
      MODE_ARRIVE: return SCORE_W'(spd);
      default: begin
        sum = (SCORE_W+1)'(dv) + (SCORE_W+1)'(prod[PROD_W-1:8]);
        return sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
      end
    endcase
  endfunction

  // True when a kept entry sorts strictly ahead of the candidate
  function automatic bit sorts_ahead(input entry_t kept, input entry_t cand);
    if (kept.score != cand.score) return kept.score < cand.score;
    if (kept.depart_time != cand.depart_time) return kept.depart_time < cand.depart_time;
    return kept.flight_time < cand.flight_time;
  endfunction

  // Apply one input word to the kept list and return the word it yields
  function automatic result_word_t rank_or_read(input logic op, input logic feas,
                                                input logic [31:0] dep, fl, dv, spd,
                                                input logic [3:0] revs,
                                                input logic [5:0] ridx);
    result_word_t res;
    entry_t       cand;
    int           lim, cnt, pos, last, j;
    res = '0;
    res.insert_rank = keep_reg;
    lim = (keep_reg < MAX_KEEP) ? int'(keep_reg) : MAX_KEEP;
    if (op == OP_OFFER) begin
      if (feas && lim > 0) begin
        cand.score        = candidate_score(dv, spd);
        cand.depart_time  = dep;
        cand.flight_time  = fl;
        cand.depart_dv    = dv;
        cand.arrive_speed = spd;
        cand.revs         = revs;
        cnt = (list_len > MAX_KEEP) ? MAX_KEEP : list_len;
        pos = 0;
        while (pos < cnt && sorts_ahead(rank_list[pos], cand)) pos++;
        // insert ahead of equal keys, shifting the tail and dropping the worst
        if (pos < lim) begin
          last = (cnt < lim) ? cnt : lim - 1;
          for (j = last; j > pos; j--) rank_list[j] = rank_list[j-1];
          rank_list[pos] = cand;
          res.insert_rank = CNT_W'(pos);
        end
        list_len = (cnt + 1 > lim) ? lim : cnt + 1;
      end
    end else if (int'(ridx) < list_len && int'(ridx) < MAX_KEEP) begin
      res.entry_valid  = 1'b1;
      res.score        = rank_list[ridx].score;
      res.depart_time  = rank_list[ridx].depart_time;
      res.flight_time  = rank_list[ridx].flight_time;
      res.depart_dv    = rank_list[ridx].depart_dv;
      res.arrive_speed = rank_list[ridx].arrive_speed;
      res.revs         = rank_list[ridx].revs;
    end
    res.list_count = CNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      mode_reg   = SCORE_MODE_RST;
      weight_reg = ARRIVAL_WEIGHT_RST;
      keep_reg   = KEEP_COUNT_RST;
      list_len   = 0;
      awaited_results.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      // compare a returned word with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_entry_valid, out_entry_score, out_entry_depart_time,
                out_entry_flight_time, out_entry_depart_dv, out_entry_arrive_speed,
                out_entry_revolutions, out_list_count, out_insert_rank};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result word with nothing predicted: valid=%b score=%h cnt=%0d",
                     $time, got.entry_valid, got.score, got.list_count);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result word differs", $time);
              $display("  exp valid=%b score=%h dep=%h fl=%h dv=%h spd=%h revs=%h cnt=%0d rank=%0d",
                       want.entry_valid, want.score, want.depart_time, want.flight_time,
                       want.depart_dv, want.arrive_speed, want.revs, want.list_count,
                       want.insert_rank);
              $display("  got valid=%b score=%h dep=%h fl=%h dv=%h spd=%h revs=%h cnt=%0d rank=%0d",
                       got.entry_valid, got.score, got.depart_time, got.flight_time,
                       got.depart_dv, got.arrive_speed, got.revs, got.list_count,
                       got.insert_rank);
            end
          end
        end
      end
      // track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCORE_MODE:     mode_reg   = cfg_data[MODE_W-1:0];
          CFG_ARRIVAL_WEIGHT: weight_reg = cfg_data[WEIGHT_W-1:0];
          CFG_KEEP_COUNT:     keep_reg   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // predict the word for each accepted input, appended at the tail
      if (in_valid && !in_stall)
        awaited_results.insert(awaited_results.size(),
                               rank_or_read(in_opcode, in_feasible, in_depart_time,
                                            in_flight_time, in_depart_dv,
                                            in_arrive_speed, in_revolution_count,
                                            in_read_index));
      pending = awaited_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Top of the top-k keeper testbench: clock, reset, stimulus, stall control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wstk_pkg::*;

  localparam int KEEP_SLOTS = MAX_KEEP_DEF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = 1'b0;
  logic                  in_feasible = 1'b0;
  logic [31:0]           in_depart_time = '0;
  logic [31:0]           in_flight_time = '0;
  logic [31:0]           in_depart_dv = '0;
  logic [31:0]           in_arrive_speed = '0;
  logic [3:0]            in_revolution_count = '0;
  logic [5:0]            in_read_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_entry_valid;
  logic [39:0]           out_entry_score;
  logic [31:0]           out_entry_depart_time;
  logic [31:0]           out_entry_flight_time;
  logic [31:0]           out_entry_depart_dv;
  logic [31:0]           out_entry_arrive_speed;
  logic [3:0]            out_entry_revolutions;
  logic [6:0]            out_list_count;
  logic [6:0]            out_insert_rank;

  int mismatches;
  int pending;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  weighted_score_top_k_keeper_top #(.MAX_KEEP(KEEP_SLOTS)) uut (.*);

  wstk_ranking_checker #(.MAX_KEEP(KEEP_SLOTS)) chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("weighted_score_top_k_keeper_top: mismatch");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 13);
      end
    end
  end

  // Offer one word, idling at random first; hold it until accepted
  task automatic send_word(input logic op, input logic feas,
                           input logic [31:0] dep, fl, dv, spd,
                           input logic [3:0] revs, input logic [5:0] ridx);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= op;
    in_feasible         <= feas;
    in_depart_time      <= dep;
    in_flight_time      <= fl;
    in_depart_dv        <= dv;
    in_arrive_speed     <= spd;
    in_revolution_count <= revs;
    in_read_index       <= ridx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer(input logic feas, input logic [31:0] dep, fl, dv, spd,
                       input logic [3:0] revs);
    send_word(OP_OFFER, feas, dep, fl, dv, spd, revs, 6'($urandom));
  endtask

  task automatic read_rank(input logic [5:0] idx);
    send_word(OP_READ, 1'($urandom), $urandom, $urandom, $urandom, $urandom,
              4'($urandom), idx);
  endtask

  // Values clustered near zero so that keys tie often, with extremes mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 3));
      4:          return '0;
      5:          return '1;
      default:    return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      read_rank(($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 9)));
    else
      offer(pick >= 38, pick_value(), pick_value(), pick_value(), pick_value(),
            4'($urandom));
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [MODE_W-1:0] mode,
                            input logic [WEIGHT_W-1:0] weight,
                            input logic [CNT_W-1:0] keep);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCORE_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_ARRIVAL_WEIGHT;
    cfg_data  <= weight;
    @(posedge clk);
    cfg_index <= CFG_KEEP_COUNT;
    cfg_data  <= CFG_DATA_W'(keep);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode,
                           input logic [WEIGHT_W-1:0] weight,
                           input logic [CNT_W-1:0] keep, input int words);
    settle();
    write_regs(mode, weight, keep);
    repeat (words) send_random();
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: saturation, ties, key order, overflow and out-of-range reads
    write_regs(MODE_WEIGHTED, 16'hFFFF, 7'd8);
    read_rank(6'd0);
    offer(1'b1, '1, '1, '1, '1, 4'hF);
    offer(1'b0, 32'd5, 32'd5, '0, '0, 4'h1);
    offer(1'b1, '0, '0, '0, '0, 4'h0);
    offer(1'b1, '0, '0, '0, '0, 4'h5);
    offer(1'b1, 32'd0, 32'd1, '0, '0, 4'h3);
    offer(1'b1, 32'd1, 32'd0, '0, '0, 4'h6);
    read_rank(6'd1);
    read_rank(6'd4);
    read_rank(6'd5);
    read_rank(6'd63);
    for (int i = 1; i <= 5; i++)
      offer(1'b1, 32'(i), 32'(i), 32'(i * 256), '0, 4'(i));
    offer(1'b1, 32'd7, 32'd7, '1, '1, 4'h2);
    read_rank(6'd7);

    // Shrink the limit below the count: entries stay until the next feasible offer
    settle();
    write_regs(MODE_WEIGHTED, 16'hFFFF, 7'd3);
    read_rank(6'd5);
    offer(1'b1, '1, '1, '1, '1, 4'hA);
    read_rank(6'd5);
    read_rank(6'd2);

    // Zero limit takes no new entries
    settle();
    write_regs(MODE_WEIGHTED, 16'hFFFF, 7'd0);
    offer(1'b1, '0, '0, '0, '0, 4'h1);
    read_rank(6'd0);

    // Random phases across all modes and a range of limits
    run_phase(MODE_DEPART, 16'h0100, 7'd4, 60);
    run_phase(MODE_TOTAL, 16'($urandom), 7'd1, 50);
    run_phase(MODE_ARRIVE, 16'($urandom), 7'd64, 20);
    hold_req = 1'b1;
    repeat (60) send_random();
    run_phase(MODE_WEIGHTED, 16'h0000, 7'd8, 60);
    quiet = 1'b1;
    run_phase(MODE_WEIGHTED, 16'hFFFF, 7'd8, 70);
    quiet = 1'b0;
    run_phase(MODE_WEIGHTED, 16'h0100, 7'd2, 50);
    run_phase(MODE_WEIGHTED, 16'($urandom), 7'd0, 30);
    run_phase(MODE_TOTAL, 16'($urandom), 7'($urandom_range(0, 64)), 70);
    run_phase(MODE_WEIGHTED, 16'($urandom), 7'd8, 70);

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("weighted_score_top_k_keeper_top: match");
    end else begin
      $display("weighted_score_top_k_keeper_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wstk_pkg.sv
rtl/core/wstk_front.sv
rtl/core/wstk_queue.sv
rtl/core/wstk_back.sv
rtl/core/weighted_score_top_k_keeper_top.sv
rtl/core/wstk_checker.sv
dv/wstk_ranking_checker.sv
dv/tb_top.sv
